### hdl/cbt_pkg.sv
// Shared constants and types for the contact breaking test pipeline.
package cbt_pkg;

   localparam int ThrBits   = 20;
   localparam int ThrReset  = 20;
   localparam int RotStages = 4;

   typedef struct packed {
      logic [RotStages-1:0] load;
   } rot_ctrl_type;

endpackage

### hdl/contact_break_test.sv
// Top level: pipelined contact breaking test.
//
// Each request on the req_ channel carries one contact point: both body-local
// pivots, the contact normal, and both bodies' positions and quaternions.
// The block answers every request with exactly one response on the rsp_
// channel holding the three removal flags, in request order.
// Both channels use valid/stall: a transfer happens on a clock edge with
// valid high and stall low.
// A new request is taken every cycle while req_stall is low. The depth is
// set by the exact wide arithmetic: four stages of pivot rotation, then
// separation, normal distance, tangential remainder and its square, each
// split into registered partial products.
// When rsp_stall holds, the pipeline closes its empty slots first and
// raises req_stall only once every stage holds a request.
// csr_wr_en writes the breaking threshold; write it only while idle.
// Synchronous reset empties the pipeline and sets the threshold to 20.
module contact_break_test import cbt_pkg::*; #(
   parameter int VEC_COMPONENT_BITS  = 21,
   parameter int QUAT_COMPONENT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [3*VEC_COMPONENT_BITS-1:0]    req_pivot_on_a,
   input  logic [3*VEC_COMPONENT_BITS-1:0]    req_pivot_on_b,
   input  logic [3*VEC_COMPONENT_BITS-1:0]    req_contact_normal,
   input  logic [3*VEC_COMPONENT_BITS-1:0]    req_position_a,
   input  logic [4*QUAT_COMPONENT_BITS-1:0]   req_rotation_a,
   input  logic [3*VEC_COMPONENT_BITS-1:0]    req_position_b,
   input  logic [4*QUAT_COMPONENT_BITS-1:0]   req_rotation_b,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_remove_point,
   output logic                               rsp_too_far_apart,
   output logic                               rsp_slid_too_far,
   input  logic                               csr_wr_en,
   input  logic [ThrBits-1:0]                 csr_wr_data
);

   localparam int V      = VEC_COMPONENT_BITS;
   localparam int Q      = QUAT_COMPONENT_BITS;
   localparam int QF     = Q - 2;
   localparam int NF     = V - 2;
   localparam int WP     = 2 * Q + V + 5;
   localparam int WD     = WP + 1;
   localparam int DL     = (WD + 1) / 2;
   localparam int PLW    = DL + 1 + V;
   localparam int PHW    = WD - DL + V;
   localparam int WND    = WD + V + 2;
   localparam int LQ     = (WND + 2) / 3;
   localparam int PQL    = LQ + 1 + V;
   localparam int PQH    = WND - 2 * LQ + V;
   localparam int WT     = WND + V + 1;
   localparam int Limbs  = 4;
   localparam int TL     = (WT + Limbs - 1) / Limbs;
   localparam int MW     = Limbs * TL;
   localparam int PPW    = 2 * TL;
   localparam int RW     = (Limbs + 1) * TL + 2;
   localparam int SQW    = 2 * MW;
   localparam int TW     = SQW + 2;
   localparam int NSH    = 2 * QF + NF;
   localparam int NHW    = WND - NSH;
   localparam int TSH    = 4 * QF + 4 * NF;
   localparam int THW    = TW - TSH;
   localparam int Stages = 15;

   function automatic logic signed [V-1:0] vcomp(input logic [3*V-1:0] f, input int k);
      return f[k*V +: V];
   endfunction

   logic [Stages:1]        en;
   logic [Stages-1:1]      v_in;
   logic [Stages-1:1]      v_ff;
   logic                   rsp_valid_ff;
   rot_ctrl_type           rot_ctrl;

   logic [ThrBits-1:0]     thr_ff;
   logic [2*ThrBits-1:0]   thr_sq_ff;

   logic signed [WP-1:0]   wa [3];
   logic signed [WP-1:0]   wb [3];
   logic [3*V-1:0]         nrm_ff [1:7];

   logic signed [WD-1:0]   d_in [3];
   logic signed [WD-1:0]   d_ff [5:8][3];
   logic signed [PLW-1:0]  pl_in [3];
   logic signed [PLW-1:0]  pl_ff [3];
   logic signed [PHW-1:0]  ph_in [3];
   logic signed [PHW-1:0]  ph_ff [3];
   logic signed [WND-1:0]  nd_in;
   logic signed [WND-1:0]  nd_ff;
   logic signed [PQL-1:0]  pqa_in [3][2];
   logic signed [PQL-1:0]  pqa_ff [3][2];
   logic signed [PQH-1:0]  pqh_in [3];
   logic signed [PQH-1:0]  pqh_ff [3];
   logic [NHW-1:0]         nd_hi;
   logic                   far_in;
   logic                   far_ff [8:14];
   logic signed [WT-1:0]   t_in [3];
   logic signed [WT-1:0]   t_ff [3];
   logic [MW-1:0]          mag_in [3];
   logic [MW-1:0]          mag_ff [3];
   logic [PPW-1:0]         pp_in [3][Limbs][Limbs];
   logic [PPW-1:0]         pp_ff [3][Limbs][Limbs];
   logic [RW-1:0]          row_in [3][Limbs];
   logic [RW-1:0]          row_ff [3][Limbs];
   logic [SQW-1:0]         sq_in [3];
   logic [SQW-1:0]         sq_ff [3];
   logic [TW-1:0]          tsq_in;
   logic [TW-1:0]          tsq_ff;
   logic                   slid_in;
   logic                   far_out_ff;
   logic                   slid_out_ff;
   logic                   remove_out_ff;

   // stage advance: a stage loads when empty or when the next one loads
   always_comb begin
      en[Stages] = !rsp_valid_ff || !rsp_stall;
      for (int k = Stages - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[1] = req_valid;
      for (int k = 2; k < Stages; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_stall     = !en[1];
   assign rot_ctrl.load = en[RotStages:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= ThrBits'(ThrReset);
      end else begin
         for (int k = 1; k < Stages; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
         if (en[Stages]) begin
            rsp_valid_ff <= v_ff[Stages-1];
         end
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      thr_sq_ff <= (2*ThrBits)'(thr_ff) * (2*ThrBits)'(thr_ff);
   end

   cbt_rotate #(
      .VEC_COMPONENT_BITS  (V),
      .QUAT_COMPONENT_BITS (Q)
   ) u_rot_a (
      .clock (clock),
      .ctrl  (rot_ctrl),
      .piv   (req_pivot_on_a),
      .pos   (req_position_a),
      .rot   (req_rotation_a),
      .world (wa)
   );

   cbt_rotate #(
      .VEC_COMPONENT_BITS  (V),
      .QUAT_COMPONENT_BITS (Q)
   ) u_rot_b (
      .clock (clock),
      .ctrl  (rot_ctrl),
      .piv   (req_pivot_on_b),
      .pos   (req_position_b),
      .rot   (req_rotation_b),
      .world (wb)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k]  = WD'(wa[k]) - WD'(wb[k]);
         pl_in[k] = PLW'(signed'({1'b0, d_ff[5][k][DL-1:0]})) * PLW'(vcomp(nrm_ff[5], k));
         ph_in[k] = PHW'(signed'(d_ff[5][k][WD-1:DL])) * PHW'(vcomp(nrm_ff[5], k));
      end
   end

   always_comb begin
      nd_in = '0;
      for (int k = 0; k < 3; k++) begin
         nd_in = nd_in + (WND'(ph_ff[k]) <<< DL) + WND'(pl_ff[k]);
      end
   end

   always_comb begin
      nd_hi  = nd_ff[WND-1:NSH];
      far_in = !nd_ff[WND-1] && ((nd_hi > NHW'(thr_ff))
               || (nd_hi == NHW'(thr_ff) && (|nd_ff[NSH-1:0])));
      for (int k = 0; k < 3; k++) begin
         pqa_in[k][0] = PQL'(signed'({1'b0, nd_ff[LQ-1:0]})) * PQL'(vcomp(nrm_ff[7], k));
         pqa_in[k][1] = PQL'(signed'({1'b0, nd_ff[2*LQ-1:LQ]})) * PQL'(vcomp(nrm_ff[7], k));
         pqh_in[k]    = PQH'(signed'(nd_ff[WND-1:2*LQ])) * PQH'(vcomp(nrm_ff[7], k));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t_in[k] = (WT'(d_ff[8][k]) <<< (2*NF))
                 - ((WT'(pqh_ff[k]) <<< (2*LQ)) + (WT'(pqa_ff[k][1]) <<< LQ)
                 + WT'(pqa_ff[k][0]));
         mag_in[k] = MW'(t_ff[k][WT-1] ? (~t_ff[k] + 1'b1) : t_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < Limbs; i++) begin
            for (int j = 0; j < Limbs; j++) begin
               pp_in[k][i][j] = PPW'(mag_ff[k][i*TL +: TL]) * PPW'(mag_ff[k][j*TL +: TL]);
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = '0;
         for (int i = 0; i < Limbs; i++) begin
            row_in[k][i] = '0;
            for (int j = 0; j < Limbs; j++) begin
               row_in[k][i] = row_in[k][i] + (RW'(pp_ff[k][i][j]) << (TL*j));
            end
            sq_in[k] = sq_in[k] + (SQW'(row_ff[k][i]) << (TL*i));
         end
      end
      tsq_in  = TW'(sq_ff[0]) + TW'(sq_ff[1]) + TW'(sq_ff[2]);
      slid_in = (tsq_ff[TW-1:TSH] > THW'(thr_sq_ff))
             || (tsq_ff[TW-1:TSH] == THW'(thr_sq_ff) && (|tsq_ff[TSH-1:0]));
   end

   always_ff @(posedge clock) begin
      if (en[1]) nrm_ff[1] <= req_contact_normal;
      for (int k = 2; k <= 7; k++) begin
         if (en[k]) nrm_ff[k] <= nrm_ff[k-1];
      end
      if (en[5]) d_ff[5] <= d_in;
      for (int k = 6; k <= 8; k++) begin
         if (en[k]) d_ff[k] <= d_ff[k-1];
      end
      if (en[6]) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
      end
      if (en[7]) nd_ff <= nd_in;
      if (en[8]) begin
         pqa_ff    <= pqa_in;
         pqh_ff    <= pqh_in;
         far_ff[8] <= far_in;
      end
      for (int k = 9; k <= 14; k++) begin
         if (en[k]) far_ff[k] <= far_ff[k-1];
      end
      if (en[9])  t_ff   <= t_in;
      if (en[10]) mag_ff <= mag_in;
      if (en[11]) pp_ff  <= pp_in;
      if (en[12]) row_ff <= row_in;
      if (en[13]) sq_ff  <= sq_in;
      if (en[14]) tsq_ff <= tsq_in;
      if (en[15]) begin
         far_out_ff    <= far_ff[14];
         slid_out_ff   <= slid_in;
         remove_out_ff <= far_ff[14] | slid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_too_far_apart = far_out_ff;
   assign rsp_slid_too_far  = slid_out_ff;
   assign rsp_remove_point  = remove_out_ff;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (v_ff == '0 && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff) && rsp_valid_ff && rsp_stall)
      else $error("request stalled while a slot is free");

   a_last_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[Stages-1] && !en[Stages-1] |=> v_ff[Stages-1] && $stable(tsq_ff))
      else $error("held request lost in last stage");

   a_handoff: assert property (@(posedge clock) disable iff (reset)
      v_ff[Stages-1] && en[Stages] |=> rsp_valid_ff)
      else $error("request dropped at output register");

endmodule

### hdl/cbt_rotate.sv
// Four-stage pipeline: rotate a body-local pivot by a quaternion and add the body position.
module cbt_rotate import cbt_pkg::*; #(
   parameter int VEC_COMPONENT_BITS  = 21,
   parameter int QUAT_COMPONENT_BITS = 16,
   localparam int WorldBits = 2 * QUAT_COMPONENT_BITS + VEC_COMPONENT_BITS + 5
) (
   input  logic                                clock,
   input  rot_ctrl_type                        ctrl,
   input  logic [3*VEC_COMPONENT_BITS-1:0]     piv,
   input  logic [3*VEC_COMPONENT_BITS-1:0]     pos,
   input  logic [4*QUAT_COMPONENT_BITS-1:0]    rot,
   output logic signed [WorldBits-1:0]         world [3]
);

   localparam int V   = VEC_COMPONENT_BITS;
   localparam int Q   = QUAT_COMPONENT_BITS;
   localparam int QF  = Q - 2;
   localparam int SW  = 2 * Q + 2;
   localparam int UVW = Q + V;
   localparam int DVW = Q + V + 2;
   localparam int CW  = Q + V + 1;
   localparam int M1W = SW + V;
   localparam int M2W = DVW + Q;
   localparam int M3W = Q + CW;
   localparam int WP  = WorldBits;

   logic signed [V-1:0]   v0 [3];
   logic signed [V-1:0]   p0 [3];
   logic signed [Q-1:0]   u0 [3];
   logic signed [Q-1:0]   w0;

   logic signed [2*Q-1:0] sq_in [4];
   logic signed [2*Q-1:0] sq_ff [4];
   logic signed [UVW-1:0] uv_in [3][3];
   logic signed [UVW-1:0] uv_ff [3][3];
   logic signed [V-1:0]   v1_ff [3];
   logic signed [V-1:0]   p1_ff [3];
   logic signed [Q-1:0]   u1_ff [3];
   logic signed [Q-1:0]   w1_ff;

   logic signed [SW-1:0]  s_in;
   logic signed [SW-1:0]  s_ff;
   logic signed [DVW-1:0] dv_in;
   logic signed [DVW-1:0] dv_ff;
   logic signed [CW-1:0]  c_in [3];
   logic signed [CW-1:0]  c_ff [3];
   logic signed [V-1:0]   v2_ff [3];
   logic signed [V-1:0]   p2_ff [3];
   logic signed [Q-1:0]   u2_ff [3];
   logic signed [Q-1:0]   w2_ff;

   logic signed [M1W-1:0] m1_in [3];
   logic signed [M1W-1:0] m1_ff [3];
   logic signed [M2W-1:0] m2_in [3];
   logic signed [M2W-1:0] m2_ff [3];
   logic signed [M3W-1:0] m3_in [3];
   logic signed [M3W-1:0] m3_ff [3];
   logic signed [V-1:0]   p3_ff [3];

   logic signed [WP-1:0]  world_in [3];
   logic signed [WP-1:0]  world_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v0[k] = piv[k*V +: V];
         p0[k] = pos[k*V +: V];
         u0[k] = rot[k*Q +: Q];
      end
      w0 = rot[3*Q +: Q];
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (2*Q)'(u0[i]) * (2*Q)'(u0[i]);
         for (int j = 0; j < 3; j++) begin
            uv_in[i][j] = UVW'(u0[i]) * UVW'(v0[j]);
         end
      end
      sq_in[3] = (2*Q)'(w0) * (2*Q)'(w0);
   end

   always_comb begin
      s_in = SW'(sq_ff[3]) - SW'(sq_ff[0]) - SW'(sq_ff[1]) - SW'(sq_ff[2]);
      dv_in = DVW'(uv_ff[0][0]) + DVW'(uv_ff[1][1]) + DVW'(uv_ff[2][2]);
      c_in[0] = CW'(uv_ff[1][2]) - CW'(uv_ff[2][1]);
      c_in[1] = CW'(uv_ff[2][0]) - CW'(uv_ff[0][2]);
      c_in[2] = CW'(uv_ff[0][1]) - CW'(uv_ff[1][0]);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         m1_in[k] = M1W'(s_ff) * M1W'(v2_ff[k]);
         m2_in[k] = M2W'(dv_ff) * M2W'(u2_ff[k]);
         m3_in[k] = M3W'(w2_ff) * M3W'(c_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         world_in[k] = WP'(m1_ff[k]) + (WP'(m2_ff[k]) <<< 1) + (WP'(m3_ff[k]) <<< 1)
                     + (WP'(p3_ff[k]) <<< (2*QF));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         sq_ff <= sq_in;
         uv_ff <= uv_in;
         v1_ff <= v0;
         p1_ff <= p0;
         u1_ff <= u0;
         w1_ff <= w0;
      end
      if (ctrl.load[1]) begin
         s_ff  <= s_in;
         dv_ff <= dv_in;
         c_ff  <= c_in;
         v2_ff <= v1_ff;
         p2_ff <= p1_ff;
         u2_ff <= u1_ff;
         w2_ff <= w1_ff;
      end
      if (ctrl.load[2]) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
         p3_ff <= p2_ff;
      end
      if (ctrl.load[3]) begin
         world_ff <= world_in;
      end
   end

   assign world = world_ff;

endmodule
